[rtl/core/abg_pkg.sv]
`timescale 1ns / 1ps
package abg_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned UsedW        = IdxW + 1;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrW     = $clog2(FifoDepth);

  localparam logic [5:0]  HeaderBytes   = 6'd14;
  localparam logic [5:0]  ArpFrameBytes = 6'd42;
  localparam logic [15:0] ArpEthertype  = 16'h0806;
  localparam logic [5:0]  PosEthHi      = 6'd12;
  localparam logic [5:0]  PosEthLo      = 6'd13;
  localparam logic [5:0]  PosMacFirst   = 6'd22;
  localparam logic [5:0]  PosMacLast    = 6'd27;
  localparam logic [5:0]  PosIpFirst    = 6'd28;
  localparam logic [5:0]  PosIpLast     = 6'd31;

  typedef enum logic [2:0] {
    ST_SHORT   = 3'd0,
    ST_NOT_ARP = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_LEARNED = 3'd3,
    ST_MATCH   = 3'd4,
    ST_CONFLICT = 3'd5,
    ST_FULL    = 3'd6
  } abg_status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_MISS,
    B_EMIT
  } abg_back_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } abg_in_t;

  typedef struct packed {
    logic        action;
    abg_status_e status;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [47:0] stored_mac;
  } abg_res_t;

  // classified frame handed from parser to table engine
  typedef struct packed {
    logic        lookup;
    abg_status_e status;
    logic [31:0] ip;
    logic [47:0] mac;
  } abg_req_t;

endpackage

[rtl/core/abg_front.sv]
`timescale 1ns / 1ps
module abg_front import abg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  abg_in_t  in_i,
  output logic     req_push_o,
  output abg_req_t req_o
);

  logic [5:0]  pos_q, pos_d;
  logic [15:0] eth_q, eth_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] ip_q, ip_d;

  always_comb begin
    eth_d = eth_q;
    mac_d = mac_q;
    ip_d  = ip_q;
    if (pos_q == PosEthHi || pos_q == PosEthLo) begin
      eth_d = {eth_q[7:0], in_i.data_byte};
    end else if (pos_q >= PosMacFirst && pos_q <= PosMacLast) begin
      mac_d = {mac_q[39:0], in_i.data_byte};
    end else if (pos_q >= PosIpFirst && pos_q <= PosIpLast) begin
      ip_d = {ip_q[23:0], in_i.data_byte};
    end
    pos_d = (pos_q < ArpFrameBytes) ? pos_q + 6'd1 : pos_q;

    req_o.lookup = 1'b0;
    req_o.ip     = '0;
    req_o.mac    = '0;
    if (pos_d < HeaderBytes) begin
      req_o.status = ST_SHORT;
    end else if (eth_d != ArpEthertype) begin
      req_o.status = ST_NOT_ARP;
    end else if (pos_d < ArpFrameBytes) begin
      req_o.status = ST_TRUNC;
    end else begin
      req_o.status = ST_LEARNED;
      req_o.lookup = 1'b1;
      req_o.ip     = ip_d;
      req_o.mac    = mac_d;
    end
    req_push_o = accept_i && in_i.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      eth_q <= '0;
      mac_q <= '0;
      ip_q  <= '0;
    end else if (accept_i) begin
      if (in_i.last_byte) begin
        pos_q <= '0;
        eth_q <= '0;
        mac_q <= '0;
        ip_q  <= '0;
      end else begin
        pos_q <= pos_d;
        eth_q <= eth_d;
        mac_q <= mac_d;
        ip_q  <= ip_d;
      end
    end
  end

endmodule

[rtl/core/abg_fifo.sv]
`timescale 1ns / 1ps
module abg_fifo import abg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  abg_req_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output abg_req_t rdata_o
);

  abg_req_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoPtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (FifoPtrW+1)'(push_i && !full_o) - (FifoPtrW+1)'(pop_i && !empty_o);
    end
  end

endmodule

[rtl/core/abg_back.sv]
`timescale 1ns / 1ps
module abg_back import abg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     drop_on_conflict_i,
  input  logic     req_empty_i,
  input  abg_req_t req_i,
  output logic     req_pop_o,
  input  logic     res_pop_i,
  output logic     res_empty_o,
  output abg_res_t res_o
);

  // bindings fill from index 0 and are never evicted; used_q marks the valid range
  logic [79:0]     mem_q [TableEntries];
  logic [79:0]     rdata_q;
  logic            mem_we;

  abg_back_state_e state_q, state_d;
  abg_req_t        cur_q, cur_d;
  abg_status_e     st_q, st_d;
  logic [47:0]     stored_q, stored_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [UsedW-1:0] used_q, used_d;
  logic            out_v_q, out_v_d;
  abg_res_t        out_q, out_d;
  logic            slot_free;

  assign slot_free   = !out_v_q || res_pop_i;
  assign res_empty_o = !out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[used_q[IdxW-1:0]] <= {cur_q.ip, cur_q.mac};
    end
    rdata_q <= mem_q[idx_q];
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    st_d      = st_q;
    stored_d  = stored_q;
    idx_d     = idx_q;
    used_d    = used_q;
    out_v_d   = out_v_q && !res_pop_i;
    out_d     = out_q;
    req_pop_o = 1'b0;
    mem_we    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!req_empty_i) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
          st_d      = req_i.status;
          stored_d  = '0;
          idx_d     = '0;
          if (!req_i.lookup) begin
            state_d = B_EMIT;
          end else if (used_q == '0) begin
            state_d = B_MISS;
          end else begin
            state_d = B_READ;
          end
        end
      end
      B_READ: begin
        state_d = B_CMP;
      end
      B_CMP: begin
        if (rdata_q[79:48] == cur_q.ip) begin
          stored_d = rdata_q[47:0];
          st_d     = (rdata_q[47:0] == cur_q.mac) ? ST_MATCH : ST_CONFLICT;
          state_d  = B_EMIT;
        end else if ({1'b0, idx_q} + UsedW'(1) == used_q) begin
          state_d = B_MISS;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = B_READ;
        end
      end
      B_MISS: begin
        if (used_q < UsedW'(TableEntries)) begin
          mem_we = 1'b1;
          used_d = used_q + 1'b1;
          st_d   = ST_LEARNED;
        end else begin
          st_d   = ST_FULL;
        end
        state_d = B_EMIT;
      end
      B_EMIT: begin
        if (slot_free) begin
          out_v_d          = 1'b1;
          out_d.status     = st_q;
          out_d.action     = (st_q == ST_CONFLICT) && drop_on_conflict_i;
          out_d.src_ip     = cur_q.ip;
          out_d.src_mac    = cur_q.mac;
          out_d.stored_mac = stored_q;
          state_d          = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      used_q  <= '0;
      out_v_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      out_v_q <= out_v_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    st_q     <= st_d;
    stored_q <= stored_d;
    out_q    <= out_d;
  end

endmodule

[rtl/core/arp_binding_guard.sv]
`timescale 1ns / 1ps
// ARP sender IP-to-MAC binding guard.
// Input queue side: in_i carries one frame byte and a last-byte mark; a byte is
// taken on a clock edge with push high and full low: one per cycle unless full.
// Result queue side: while empty is low, res_o holds the oldest verdict (action,
// status, sender IP/MAC, stored MAC); pop high with empty low takes it.
// cfg_we_i/cfg_wdata_i write drop_on_conflict; write it only while idle.
// A parser captures each frame and, on its last byte, queues a request (4 deep)
// for the table engine, which serves one request at a time. Non-lookup requests
// go from the queue through the emit state into the result register. A lookup
// scans the stored bindings (at most 256) in fill order, each entry through a
// read state and then a compare state, and stops at the first IP hit.
// Misses learn into the next free entry; a full table never evicts.
// Reset clears the parser, the binding count (the table reads as empty, no
// clearing pass), the request queue, the result valid flag and drop_on_conflict.
// When the receiver stalls, the held result blocks the table engine, requests
// pile up in the queue, and full rises once it holds four requests.
module arp_binding_guard import abg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  abg_in_t  in_i,
  output logic     empty,
  input  logic     pop,
  output abg_res_t res_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  logic     drop_q;
  logic     accept;
  logic     req_push, req_pop, req_empty;
  abg_req_t req_w, req_r;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
    end else if (cfg_we_i) begin
      drop_q <= cfg_wdata_i;
    end
  end

  abg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_i),
    .req_push_o (req_push),
    .req_o      (req_w)
  );

  abg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_push),
    .wdata_i (req_w),
    .full_o  (full),
    .pop_i   (req_pop),
    .empty_o (req_empty),
    .rdata_o (req_r)
  );

  abg_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .drop_on_conflict_i (drop_q),
    .req_empty_i        (req_empty),
    .req_i              (req_r),
    .req_pop_o          (req_pop),
    .res_pop_i          (pop),
    .res_empty_o        (empty),
    .res_o              (res_o)
  );

endmodule

[rtl/core/abg_checker.sv]
`timescale 1ns / 1ps
module abg_checker import abg_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input abg_res_t res_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("result changed while stalled");

  a_early_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.status == ST_SHORT || res_o.status == ST_NOT_ARP ||
                res_o.status == ST_TRUNC))
    |-> (!res_o.action && res_o.src_ip == '0 && res_o.src_mac == '0 &&
         res_o.stored_mac == '0))
    else $error("early verdict carries data");

  a_learn_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.status == ST_LEARNED || res_o.status == ST_FULL))
    |-> (!res_o.action && res_o.stored_mac == '0))
    else $error("learn or full verdict malformed");

  a_match_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.status == ST_MATCH)
    |-> (!res_o.action && res_o.stored_mac == res_o.src_mac))
    else $error("match with differing MAC");

  a_conflict_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.status == ST_CONFLICT) |-> (res_o.stored_mac != res_o.src_mac))
    else $error("conflict with equal MAC");

endmodule

bind arp_binding_guard abg_checker u_abg_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);

[dv/abg_verdict_checker.sv]
`timescale 1ns / 1ps
module abg_verdict_checker import abg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  logic     full,
  input  abg_in_t  in_i,
  input  logic     empty,
  input  logic     pop,
  input  abg_res_t res_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  output int       fails_o,
  output int       pending_o
);

  logic [5:0]  pos_q;
  logic [15:0] etype_q;
  logic [47:0] mac_q;
  logic [31:0] ip_q;
  logic        drop_q;
  logic [31:0] bound_ip  [TableEntries];
  logic [47:0] bound_mac [TableEntries];
  int unsigned bound_n;
  abg_res_t    verdicts_due [$];

  function automatic abg_res_t judge_frame();
    abg_res_t r;
    bit       hit;
    r = '0;
    hit = 1'b0;
    if (pos_q < HeaderBytes) begin
      r.status = ST_SHORT;
    end else if (etype_q != ArpEthertype) begin
      r.status = ST_NOT_ARP;
    end else if (pos_q < ArpFrameBytes) begin
      r.status = ST_TRUNC;
    end else begin
      r.src_ip  = ip_q;
      r.src_mac = mac_q;
      for (int unsigned k = 0; k < bound_n && !hit; k++) begin
        if (bound_ip[k] == ip_q) begin
          hit = 1'b1;
          r.stored_mac = bound_mac[k];
        end
      end
      if (hit) begin
        if (r.stored_mac == mac_q) begin
          r.status = ST_MATCH;
        end else begin
          r.status = ST_CONFLICT;
          r.action = drop_q;
        end
      end else if (bound_n < TableEntries) begin
        bound_ip[bound_n]  = ip_q;
        bound_mac[bound_n] = mac_q;
        bound_n++;
        r.status = ST_LEARNED;
      end else begin
        r.status = ST_FULL;
      end
    end
    return r;
  endfunction

  function automatic void take_byte(abg_in_t b);
    if (pos_q == PosEthHi || pos_q == PosEthLo) begin
      etype_q = {etype_q[7:0], b.data_byte};
    end else if (pos_q >= PosMacFirst && pos_q <= PosMacLast) begin
      mac_q = {mac_q[39:0], b.data_byte};
    end else if (pos_q >= PosIpFirst && pos_q <= PosIpLast) begin
      ip_q = {ip_q[23:0], b.data_byte};
    end
    if (pos_q < ArpFrameBytes) begin
      pos_q++;
    end
    if (b.last_byte) begin
      verdicts_due.push_back(judge_frame());
      pos_q   = '0;
      etype_q = '0;
      mac_q   = '0;
      ip_q    = '0;
    end
  endfunction

  function automatic void check_field(string field, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      fails_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    abg_res_t want;
    if (!rst_ni) begin
      pos_q   = '0;
      etype_q = '0;
      mac_q   = '0;
      ip_q    = '0;
      drop_q  = 1'b0;
      bound_n = 0;
      verdicts_due.delete();
    end else begin
      if (cfg_we_i) begin
        drop_q = cfg_wdata_i;
      end
      if (push && !full) begin
        take_byte(in_i);
      end
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict popped with no request outstanding");
          fails_o++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("action", 48'(want.action), 48'(res_o.action));
          check_field("status", 48'(want.status), 48'(res_o.status));
          check_field("src_ip", 48'(want.src_ip), 48'(res_o.src_ip));
          check_field("src_mac", want.src_mac, res_o.src_mac);
          check_field("stored_mac", want.stored_mac, res_o.stored_mac);
        end
      end
    end
    pending_o = verdicts_due.size();
  end

endmodule

[dv/tb_arp_binding_guard.sv]
`timescale 1ns / 1ps
module tb_arp_binding_guard;
  import abg_pkg::*;

  localparam int unsigned DrainCycles = 2 * TableEntries + 40;
  localparam int unsigned CycleLimit  = 4_000_000;
  localparam int unsigned PoolIps     = 12;
  localparam int unsigned PoolMacs    = 4;
  localparam int unsigned PhaseBytes  = 300;
  localparam int unsigned PhaseFrames = 6;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     push      = 1'b0;
  logic     full;
  abg_in_t  in_i      = '0;
  logic     empty;
  logic     pop       = 1'b0;
  abg_res_t res_o;
  logic     cfg_we    = 1'b0;
  logic     cfg_wdata = 1'b0;

  int          fails;
  int          pending;
  int unsigned send_idle  = 0;
  int unsigned recv_idle  = 0;
  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  logic [31:0] ip_pool  [PoolIps];
  logic [47:0] mac_pool [PoolMacs];

  arp_binding_guard dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  abg_verdict_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .fails_o    (fails),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_i <= {b, last};
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input logic [15:0] etype,
                            input logic [47:0] mac, input logic [31:0] ip);
    logic [7:0] b;
    for (int unsigned p = 0; p < len; p++) begin
      b = 8'($urandom);
      if (p == PosEthHi) begin
        b = etype[15:8];
      end else if (p == PosEthLo) begin
        b = etype[7:0];
      end else if (p >= PosMacFirst && p <= PosMacLast) begin
        b = mac[47 - 8 * (p - PosMacFirst) -: 8];
      end else if (p >= PosIpFirst && p <= PosIpLast) begin
        b = ip[31 - 8 * (p - PosIpFirst) -: 8];
      end
      send_byte(b, p == len - 1);
    end
  endtask

  task automatic random_frame();
    int unsigned kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] etype;
    kind  = $urandom_range(0, 99);
    ip    = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, PoolIps - 1)];
    mac   = ($urandom_range(0, 9) == 0) ? rand_mac() : mac_pool[$urandom_range(0, PoolMacs - 1)];
    etype = ArpEthertype;
    if (kind < 8) begin
      if ($urandom_range(0, 1) == 0) begin
        etype = 16'($urandom);
      end
      send_frame($urandom_range(1, 13), etype, mac, ip);
    end else if (kind < 18) begin
      etype = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                          : ArpEthertype ^ (16'd1 << $urandom_range(0, 15));
      send_frame($urandom_range(14, 60), etype, mac, ip);
    end else if (kind < 26) begin
      send_frame($urandom_range(14, 41), etype, mac, ip);
    end else begin
      send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(43, 72) : 42, etype, mac, ip);
    end
  endtask

  // register writes only while no request is in flight
  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic set_drop(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned sidle, input int unsigned ridle, input logic drop);
    int unsigned start;
    int unsigned frames;
    set_drop(drop);
    send_idle = sidle;
    recv_idle = ridle;
    start     = bytes_sent;
    frames    = 0;
    while (bytes_sent - start < PhaseBytes || frames < PhaseFrames) begin
      random_frame();
      frames++;
    end
    settle();
  endtask

  initial begin
    for (int i = 0; i < PoolIps; i++) ip_pool[i] = $urandom;
    for (int i = 0; i < PoolMacs; i++) mac_pool[i] = rand_mac();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_drop(1'b1);
    send_frame(1, ArpEthertype, '0, '0);
    send_frame(13, ArpEthertype, '1, '1);
    send_frame(14, ArpEthertype, '1, '1);
    send_frame(14, 16'h0800, '1, '1);
    send_frame(41, ArpEthertype, '1, '1);
    send_frame(42, ArpEthertype, '1, '1);
    send_frame(42, ArpEthertype, '1, '1);
    send_frame(42, ArpEthertype, '0, '1);
    send_frame(42, ArpEthertype, '0, '0);
    send_frame(64, ArpEthertype, '0, '0);
    send_frame(42, ArpEthertype, '1, '0);
    send_frame(42, 16'h0807, '1, '0);
    send_frame(43, 16'hffff, '1, '0);
    settle();

    run_phase(33, 87, 1'b0);
    run_phase(87, 33, 1'b1);
    run_phase(0, 0, 1'b0);

    if (fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/abg_pkg.sv
rtl/core/abg_front.sv
rtl/core/abg_fifo.sv
rtl/core/abg_back.sv
rtl/core/arp_binding_guard.sv
rtl/core/abg_checker.sv
dv/abg_verdict_checker.sv
dv/tb_arp_binding_guard.sv
